// ----- rtl/ltbd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ltbd_pkg;

	// Register indexes on the configuration channel
	localparam logic CfgKey  = 1'b0;
	localparam logic CfgMask = 1'b1;

	localparam int unsigned KeyW       = 64;
	localparam int unsigned MaskW      = 8;
	localparam int unsigned WarmSteps  = 256;
	localparam int unsigned CntW       = $clog2(WarmSteps);
	localparam int unsigned ByteIdxW   = 3;
	localparam logic [MaskW-1:0] MaskReset = 8'h35;

	// Controller to datapath commands
	typedef struct packed {
		logic                accept;
		logic                seed;
		logic                step;
		logic                capture;
		logic                emit;
		logic [ByteIdxW-1:0] byte_idx;
	} ltbd_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
	} ltbd_sts_t;

endpackage
`default_nettype wire

// ----- rtl/ltbd_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ltbd_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire                 first_block,
	output logic                in_stall,
	input  ltbd_pkg::ltbd_sts_t sts,
	output ltbd_pkg::ltbd_cmd_t cmd
);
	import ltbd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WARM,
		ST_RUN,
		ST_EMIT
	} state_t;

	state_t          state_q;
	logic [CntW-1:0] cnt_q;

	// Decode commands from the current state
	always_comb begin
		in_stall     = (state_q != ST_IDLE);
		cmd.accept   = (state_q == ST_IDLE) && in_valid;
		cmd.seed     = (state_q == ST_IDLE) && in_valid && first_block;
		cmd.step     = (state_q == ST_WARM) || (state_q == ST_RUN);
		cmd.capture  = (state_q == ST_RUN);
		cmd.emit     = (state_q == ST_EMIT) && sts.out_free;
		cmd.byte_idx = cnt_q[ByteIdxW-1:0];
	end

	// Sequence warm-up steps, eight keystream bytes, then the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						state_q <= first_block ? ST_WARM : ST_RUN;
					end
				end
				ST_WARM: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(WarmSteps - 1)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[ByteIdxW-1:0] == '1) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/ltbd_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ltbd_dp (
	input  wire                          clk,
	input  wire                          arst_n,
	input  ltbd_pkg::ltbd_cmd_t          cmd,
	output ltbd_pkg::ltbd_sts_t          sts,
	input  wire                          cfg_valid,
	input  wire                          cfg_index,
	input  wire  [ltbd_pkg::KeyW-1:0]    cfg_data,
	input  wire  [ltbd_pkg::KeyW-1:0]    cipher_block,
	output logic [ltbd_pkg::KeyW-1:0]    plain_block,
	output logic                         out_valid,
	input  wire                          out_stall
);
	import ltbd_pkg::*;

	logic [KeyW-1:0]  key_q;
	logic [MaskW-1:0] mask_init_q;
	logic [KeyW-1:0]  ks_q;
	logic [MaskW-1:0] mask_q;
	logic [KeyW-1:0]  cipher_q;
	logic [KeyW-1:0]  src_q;
	logic [KeyW-1:0]  out_q;
	logic             out_valid_q;
	logic [KeyW-1:0]  ks_next;
	logic [KeyW-1:0]  seed_val;
	logic [KeyW-1:0]  plain_val;
	logic             mask_lsb;

	// One generator step: four passes of the byte-wise right shift
	function automatic logic [KeyW-1:0] gen_step(input logic [KeyW-1:0] r_in);
		logic [KeyW-1:0] r;
		logic [KeyW-1:0] n;
		logic            fb;
		r = r_in;
		for (int p = 0; p < 4; p++) begin
			fb = r[57] ^ r[59];
			n[7:0] = {fb, r[7:1]};
			for (int i = 1; i < 8; i++) begin
				n[8*i +: 8] = {r[8*(i-1)], r[8*i+1 +: 7]};
			end
			r = n;
		end
		return r;
	endfunction

	always_comb begin
		ks_next = gen_step(ks_q);
		for (int i = 0; i < 8; i++) begin
			seed_val[8*i +: 8] = key_q[8*i +: 8] + 8'd1;
		end
		// Transpose the 8x8 bit matrix and apply the mask
		for (int j = 0; j < 8; j++) begin
			for (int i = 0; i < 8; i++) begin
				plain_val[8*j+i] = src_q[8*i+j] ^ mask_q[i];
			end
		end
		mask_lsb     = mask_q[0];
		sts.out_free = !out_valid_q || !out_stall;
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q       <= '0;
			mask_init_q <= MaskReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CfgKey:  key_q       <= cfg_data;
				CfgMask: mask_init_q <= cfg_data[MaskW-1:0];
				default: ;
			endcase
		end
	end

	// Advance keystream register and mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_q   <= '0;
			mask_q <= '0;
		end else begin
			if (cmd.seed) begin
				ks_q   <= seed_val;
				mask_q <= mask_init_q;
			end else begin
				if (cmd.step) begin
					ks_q <= ks_next;
				end
				if (cmd.emit) begin
					mask_q <= {mask_lsb, mask_q[MaskW-1:1]} + {{(MaskW-1){1'b0}}, mask_lsb};
				end
			end
		end
	end

	// Capture the input beat, build the source bytes and register the result
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cipher_q <= cipher_block;
		end
		if (cmd.capture) begin
			src_q[8*cmd.byte_idx +: 8] <= cipher_q[8*cmd.byte_idx +: 8] ^ ks_next[7:0];
		end
		if (cmd.emit) begin
			out_q <= plain_val;
		end
	end

	// Output register valid: set on emit, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign plain_block = out_q;
	assign out_valid   = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/lfsr_transpose_block_decrypt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Block decryptor for 8-byte blocks: each cipher byte is XORed with a keystream byte
// from a 64-bit shift register, the 8x8 bit matrix is transposed and every byte is
// XORed with a rotating mask. One keystream byte is produced per cycle: a block is
// taken while idle, its eight keystream bytes come in the run state and the result
// is registered in the emit state; a block with first_block set first reseeds from
// key_bytes and runs 256 warm-up steps. One block is in flight at a time; the output
// register lets the next block start while a result waits to be taken.
// Configuration (index 0 key_bytes, index 1 mask_init) is always ready and should be
// written only while no block is in flight.
module lfsr_transpose_block_decrypt (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_valid,
	output logic                      cfg_ready,
	input  wire                       cfg_index,
	input  wire  [ltbd_pkg::KeyW-1:0] cfg_data,
	input  wire                       in_valid,
	output logic                      in_stall,
	input  wire  [ltbd_pkg::KeyW-1:0] cipher_block,
	input  wire                       first_block,
	output logic                      out_valid,
	input  wire                       out_stall,
	output logic [ltbd_pkg::KeyW-1:0] plain_block
);
	import ltbd_pkg::*;

	ltbd_cmd_t cmd;
	ltbd_sts_t sts;

	assign cfg_ready = 1'b1;

	ltbd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.first_block (first_block),
		.in_stall    (in_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	ltbd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cipher_block (cipher_block),
		.plain_block  (plain_block),
		.out_valid    (out_valid),
		.out_stall    (out_stall)
	);

endmodule
`default_nettype wire

// ----- rtl/ltbd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ltbd_checker (
	input wire                       clk,
	input wire                       arst_n,
	input wire                       cfg_ready,
	input wire                       in_valid,
	input wire                       in_stall,
	input wire                       first_block,
	input wire                       out_valid,
	input wire                       out_stall,
	input wire [ltbd_pkg::KeyW-1:0]  plain_block
);

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(plain_block))
		else $error("stalled result beat changed");

	// The input stays stalled while the keystream bytes of any input beat are generated
	a_busy_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##8 in_stall)
		else $error("block finished before its keystream bytes");

	// Warm-up keeps the input stalled well past the keystream cycles
	a_busy_warm: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && first_block |-> ##200 in_stall)
		else $error("warm-up cut short");

	// Configuration is always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration not ready");

endmodule

bind lfsr_transpose_block_decrypt ltbd_checker u_ltbd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_ready   (cfg_ready),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.first_block (first_block),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.plain_block (plain_block)
);
`default_nettype wire

// ----- dv/plain_block_checker.sv -----
`timescale 1ns / 1ps
module plain_block_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_valid,
	input  wire        cfg_ready,
	input  wire        cfg_index,
	input  wire [63:0] cfg_data,
	input  wire        in_valid,
	input  wire        in_stall,
	input  wire [63:0] cipher_block,
	input  wire        first_block,
	input  wire        out_valid,
	input  wire        out_stall,
	input  wire [63:0] plain_block,
	output int         fail_count,
	output int         pending
);
	import ltbd_pkg::*;

	localparam int unsigned PassesPerStep = 4;
	localparam int unsigned ReportLimit   = 10;

	// Shadow copies of the registers and the decryptor state
	logic [KeyW-1:0]  key_shadow;
	logic [MaskW-1:0] mask_init_shadow;
	logic [63:0]      ks_reg;
	logic [MaskW-1:0] block_mask;
	logic [63:0]      expected_plain[$];
	int               mismatches;

	assign fail_count = mismatches;

	// Advance the keystream register by one step and return its new byte 0
	function automatic logic [7:0] keystream_byte();
		logic [7:0] r[8];
		logic       fb;
		for (int i = 0; i < 8; i++) r[i] = ks_reg[8*i +: 8];
		for (int p = 0; p < PassesPerStep; p++) begin
			fb = r[7][1] ^ r[7][3];
			for (int i = 7; i > 0; i--) r[i] = {r[i-1][0], r[i][7:1]};
			r[0] = {fb, r[0][7:1]};
		end
		for (int i = 0; i < 8; i++) ks_reg[8*i +: 8] = r[i];
		return r[0];
	endfunction

	// Work out the plaintext of one block and update the state
	function automatic logic [63:0] decrypt_block(logic [63:0] cb, logic reseed);
		logic [7:0]  src[8];
		logic [63:0] plain;
		logic        lowbit;
		if (reseed) begin
			for (int i = 0; i < 8; i++) ks_reg[8*i +: 8] = key_shadow[8*i +: 8] + 8'd1;
			repeat (WarmSteps) void'(keystream_byte());
			block_mask = mask_init_shadow;
		end
		for (int i = 0; i < 8; i++) src[i] = cb[8*i +: 8] ^ keystream_byte();
		// transpose the bit matrix, then apply the mask to every byte
		for (int j = 0; j < 8; j++)
			for (int i = 0; i < 8; i++)
				plain[8*j + i] = src[i][j] ^ block_mask[i];
		lowbit = block_mask[0];
		block_mask = {lowbit, block_mask[MaskW-1:1]} + MaskW'(lowbit);
		return plain;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [63:0] want;
		if (!arst_n) begin
			key_shadow       = '0;
			mask_init_shadow = MaskReset;
			ks_reg           = '0;
			block_mask       = '0;
			mismatches       = 0;
			expected_plain.delete();
			pending <= 0;
		end else begin
			// track register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CfgKey:  key_shadow = cfg_data;
					CfgMask: mask_init_shadow = cfg_data[MaskW-1:0];
				endcase
			end
			// compare a result beat with the oldest expectation
			if (out_valid && !out_stall) begin
				if (expected_plain.size() == 0) begin
					if (mismatches < ReportLimit)
						$display("%0t: unexpected plain_block %h", $realtime, plain_block);
					mismatches++;
				end else begin
					want = expected_plain.pop_front();
					if (plain_block !== want) begin
						if (mismatches < ReportLimit)
							$display("%0t: plain_block expected %h actual %h",
								$realtime, want, plain_block);
						mismatches++;
					end
				end
			end
			// predict the result of an input beat
			if (in_valid && !in_stall)
				expected_plain.push_back(decrypt_block(cipher_block, first_block));
			pending <= expected_plain.size();
		end
	end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import ltbd_pkg::*;

	localparam int unsigned CycleLimit  = 1500000;
	localparam int unsigned RandPhases  = 6;
	localparam int unsigned PhaseBlocks = 250;
	localparam int unsigned SettleCyc   = 4;
	localparam int unsigned TailCyc     = 12;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] cipher_block;
	logic        first_block;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] plain_block;
	logic        calm;
	int          fail_count;
	int          pending;
	int unsigned cycles = 0;

	lfsr_transpose_block_decrypt uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cipher_block(cipher_block),
		.first_block (first_block),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.plain_block (plain_block)
	);

	plain_block_checker u_plain_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cipher_block(cipher_block),
		.first_block (first_block),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.plain_block (plain_block),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the result channel at random, except in a calm stretch
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 8);
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Present one block and hold it until it is taken
	task automatic send_block(input logic [63:0] cb, input logic reseed);
		if (!calm && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 50) @(posedge clk);
		end
		in_valid     <= 1'b1;
		cipher_block <= cb;
		first_block  <= reseed;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Hold off input until every result is back and the block is idle again
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SettleCyc) @(posedge clk);
	endtask

	// Write both registers, in random order, then drop the write channel
	task automatic load_settings(input logic [63:0] key, input logic [7:0] mask);
		logic mask_first;
		mask_first = 1'($urandom_range(1));
		cfg_valid <= 1'b1;
		cfg_index <= mask_first ? CfgMask : CfgKey;
		cfg_data  <= mask_first ? {56'd0, mask} : key;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= mask_first ? CfgKey : CfgMask;
		cfg_data  <= mask_first ? key : {$urandom, 24'd0, mask};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [63:0] key;
		logic [7:0]  mask;
		logic [63:0] cb;
		calm         = 1'b0;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CfgKey;
		cfg_data     = '0;
		in_valid     = 1'b0;
		cipher_block = '0;
		first_block  = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// blocks before any reseed: zero register and zero mask
		send_block(64'h0, 1'b0);
		send_block('1, 1'b0);
		send_block(64'h0123_4567_89ab_cdef, 1'b0);
		// reseed with the reset key and mask
		send_block(64'h0, 1'b1);
		send_block('1, 1'b0);
		send_block(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
		send_block(64'h5555_5555_5555_5555, 1'b0);
		send_block(64'h8000_0000_0000_0001, 1'b0);
		drain();

		// all-ones key wraps every register byte to zero
		load_settings('1, 8'hff);
		send_block(64'h0, 1'b1);
		send_block('1, 1'b0);
		send_block(64'hff00_ff00_ff00_ff00, 1'b0);
		send_block({$urandom, $urandom}, 1'b0);
		drain();

		// zero bytes inside the key, back-to-back reseeds
		load_settings(64'h00ff_0000_7f80_0001, 8'h00);
		send_block(64'h0f0f_0f0f_0f0f_0f0f, 1'b1);
		send_block(64'hf0f0_f0f0_f0f0_f0f0, 1'b1);
		send_block('1, 1'b0);
		drain();

		// odd and top-bit mask values
		load_settings(64'h0, 8'h01);
		send_block(64'h0, 1'b1);
		send_block(64'h0, 1'b0);
		drain();
		load_settings({$urandom, $urandom}, 8'h80);
		send_block({$urandom, $urandom}, 1'b1);
		send_block({$urandom, $urandom}, 1'b0);
		drain();

		// random phases, each with its own settings
		for (int ph = 0; ph < RandPhases; ph++) begin
			calm = (ph == 2);
			case ($urandom_range(3))
				0: key = '0;
				1: key = '1;
				default: key = {$urandom, $urandom};
			endcase
			for (int b = 0; b < 8; b++)
				if ($urandom_range(7) == 0) key[8*b +: 8] = $urandom_range(1) ? 8'h00 : 8'hff;
			case ($urandom_range(3))
				0: mask = 8'h00;
				1: mask = 8'hff;
				default: mask = 8'($urandom_range(255));
			endcase
			load_settings(key, mask);
			for (int n = 0; n < PhaseBlocks; n++) begin
				case ($urandom_range(15))
					0: cb = '0;
					1: cb = '1;
					default: cb = {$urandom, $urandom};
				endcase
				send_block(cb, (n == 0) ? ($urandom_range(3) != 0) : ($urandom_range(11) == 0));
			end
			drain();
		end
		calm = 1'b0;

		repeat (TailCyc) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
